FILE: design/phase_lifecycle_latency_tracker_macros.svh
// Assertion macros for the phase lifecycle latency tracker, included by plt_lifecycle
`ifndef PHASE_LIFECYCLE_LATENCY_TRACKER_MACROS_SVH
`define PHASE_LIFECYCLE_LATENCY_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLT_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PLT_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/plt_pkg.sv
// Shared types and constants for the phase lifecycle latency tracker
package plt_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned NUM_SUM = 6;
  localparam int unsigned IN_DATA_W  = 4 * WORD_W;
  localparam int unsigned OUT_DATA_W = NUM_SUM * WORD_W;

  localparam int unsigned IX_CSUM = 0;
  localparam int unsigned IX_CCNT = 1;
  localparam int unsigned IX_SSUM = 2;
  localparam int unsigned IX_SCNT = 3;
  localparam int unsigned IX_FSUM = 4;
  localparam int unsigned IX_FCNT = 5;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_BEGIN    = 3'd0,
    FN_BIND     = 3'd1,
    FN_RETAINS  = 3'd2,
    FN_NOTIFY   = 3'd3,
    FN_RETIRE   = 3'd4,
    FN_TERMINAL = 3'd5,
    FN_ABORT    = 3'd6
  } func_t;

  typedef struct packed {
    logic retired;
    logic notified;
    logic bound;
    logic active;
  } flags_t;

  typedef struct packed {
    logic ok;
    logic set_begin;
    logic set_notify;
    logic set_retire;
    logic close;
    logic close_notified;
  } plt_ctl_t;

  typedef struct packed {
    word_t vblank;
    word_t bank_id;
    word_t snapshot_id;
    word_t generation;
  } request_t;

endpackage

FILE: design/plt_lifecycle.sv
// Phase state (generation, tokens, flags) and per-request accept decision
module plt_lifecycle
  import plt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  func_t    func,
  input  request_t req,
  output plt_ctl_t ctl
);

  `include "phase_lifecycle_latency_tracker_macros.svh"

  word_t  active_gen_r, active_gen_nxt;
  word_t  held_snap_r, held_snap_nxt;
  word_t  held_bank_r, held_bank_nxt;
  flags_t flags_r, flags_nxt;

  logic gen_match;
  logic retains;

  assign gen_match = (req.generation == active_gen_r);
  assign retains   = flags_r.active && flags_r.bound && gen_match &&
                     (req.snapshot_id == held_snap_r) && (req.bank_id == held_bank_r);

  always_comb begin
    ctl            = '0;
    active_gen_nxt = active_gen_r;
    held_snap_nxt  = held_snap_r;
    held_bank_nxt  = held_bank_r;
    flags_nxt      = flags_r;
    case (func)
      FN_BEGIN: begin
        if ((req.generation != '0) && !flags_r.active) begin
          ctl.ok         = 1'b1;
          ctl.set_begin  = 1'b1;
          active_gen_nxt = req.generation;
          held_snap_nxt  = '0;
          held_bank_nxt  = '0;
          flags_nxt      = '{retired: 1'b0, notified: 1'b0, bound: 1'b0, active: 1'b1};
        end
      end
      FN_BIND: begin
        if (flags_r.active && !flags_r.bound && gen_match &&
            (req.snapshot_id != '0) && (req.bank_id != '0)) begin
          ctl.ok          = 1'b1;
          held_snap_nxt   = req.snapshot_id;
          held_bank_nxt   = req.bank_id;
          flags_nxt.bound = 1'b1;
        end
      end
      FN_RETAINS: begin
        ctl.ok = retains;
      end
      FN_NOTIFY: begin
        if (flags_r.active && flags_r.bound && !flags_r.notified && gen_match) begin
          ctl.ok             = 1'b1;
          ctl.set_notify     = 1'b1;
          flags_nxt.notified = 1'b1;
        end
      end
      FN_RETIRE: begin
        if (flags_r.active && flags_r.notified && !flags_r.retired && gen_match) begin
          ctl.ok            = 1'b1;
          ctl.set_retire    = 1'b1;
          flags_nxt.retired = 1'b1;
        end
      end
      FN_TERMINAL: begin
        if (retains && !(flags_r.notified && !flags_r.retired)) begin
          ctl.ok             = 1'b1;
          ctl.close          = 1'b1;
          ctl.close_notified = flags_r.notified;
          active_gen_nxt     = '0;
          held_snap_nxt      = '0;
          held_bank_nxt      = '0;
          flags_nxt          = '0;
        end
      end
      FN_ABORT: begin
        if (flags_r.active && !flags_r.notified && gen_match) begin
          ctl.ok         = 1'b1;
          ctl.close      = 1'b1;
          active_gen_nxt = '0;
          held_snap_nxt  = '0;
          held_bank_nxt  = '0;
          flags_nxt      = '0;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_gen_r <= '0;
      held_snap_r  <= '0;
      held_bank_r  <= '0;
      flags_r      <= '0;
    end else if (fire) begin
      active_gen_r <= active_gen_nxt;
      held_snap_r  <= held_snap_nxt;
      held_bank_r  <= held_bank_nxt;
      flags_r      <= flags_nxt;
    end
  end

  `PLT_ASSERT_IMP(a_bound_needs_active, clk, rst_n, flags_r.bound, flags_r.active,
                  "bound phase without active flag")
  `PLT_ASSERT_IMP(a_notified_needs_bound, clk, rst_n, flags_r.notified, flags_r.bound,
                  "notified phase that is not bound")
  `PLT_ASSERT_IMP(a_retired_needs_notified, clk, rst_n, flags_r.retired, flags_r.notified,
                  "retired phase that was never notified")
  `PLT_ASSERT_IMP(a_active_gen_nonzero, clk, rst_n, flags_r.active, active_gen_r != '0,
                  "active phase with generation zero")
  `PLT_ASSERT_NXT(a_close_clears, clk, rst_n, fire && ctl.close, flags_r == '0,
                  "closed phase left flags set")

endmodule

FILE: design/plt_accum.sv
// Vblank stamps and wrapping span sums and counts
module plt_accum
  import plt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  plt_ctl_t                    ctl,
  input  word_t                       vblank,
  output logic [NUM_SUM-1:0][WORD_W-1:0] sums_nxt
);

  word_t begin_stamp_r;
  word_t notify_stamp_r;
  word_t retire_stamp_r;
  logic [NUM_SUM-1:0][WORD_W-1:0] sums_r;

  word_t fin_span;
  word_t slave_span;
  word_t cons_span;

  assign fin_span   = vblank - retire_stamp_r;
  assign slave_span = retire_stamp_r - notify_stamp_r;
  assign cons_span  = ctl.close_notified ? ((notify_stamp_r - begin_stamp_r) + fin_span)
                                         : (vblank - begin_stamp_r);

  always_comb begin
    sums_nxt = sums_r;
    if (ctl.close) begin
      sums_nxt[IX_CSUM] = sums_r[IX_CSUM] + cons_span;
      sums_nxt[IX_CCNT] = sums_r[IX_CCNT] + WORD_W'(1);
      if (ctl.close_notified) begin
        sums_nxt[IX_SSUM] = sums_r[IX_SSUM] + slave_span;
        sums_nxt[IX_SCNT] = sums_r[IX_SCNT] + WORD_W'(1);
        sums_nxt[IX_FSUM] = sums_r[IX_FSUM] + fin_span;
        sums_nxt[IX_FCNT] = sums_r[IX_FCNT] + WORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_stamp_r  <= '0;
      notify_stamp_r <= '0;
      retire_stamp_r <= '0;
      sums_r         <= '0;
    end else if (fire) begin
      if (ctl.set_begin) begin
        begin_stamp_r <= vblank;
      end
      if (ctl.set_notify) begin
        notify_stamp_r <= vblank;
      end
      if (ctl.set_retire) begin
        retire_stamp_r <= vblank;
      end
      sums_r <= sums_nxt;
    end
  end

endmodule

FILE: design/phase_lifecycle_latency_tracker.sv
// Phase lifecycle latency tracker: one request in, one result out, one per
// cycle while out_tready stays high. Each accepted request lands in an input
// register, is checked against the phase state and applied once the output
// register is free or being taken, and its result (accept flag and the six
// running span sums and counts after the request) sits in an output register
// until taken. Sustained rate is one request per clock while out_tready is high;
// the phase flags, stamps and sums update as the request is applied. The input
// side keeps accepting while a result waits, until both registers are full.
module phase_lifecycle_latency_tracker
  import plt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  input  logic [IN_DATA_W-1:0]  in_tdata,   // generation, snapshot_id, bank_id, vblank
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,  // accepted
  output logic [OUT_DATA_W-1:0] out_tdata   // construction_sum, construction_total,
                                            // slave_sum, slave_total,
                                            // finalize_sum, finalize_total
);

  logic                  in_valid_r;
  func_t                 in_func_r;
  request_t              in_req_r;
  logic                  out_valid_r;
  logic                  out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic     fire;
  plt_ctl_t ctl;
  logic [NUM_SUM-1:0][WORD_W-1:0] sums_nxt;

  assign fire       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= func_t'(in_tuser);
      in_req_r  <= request_t'(in_tdata);
    end
  end

  plt_lifecycle u_lifecycle (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .func  (in_func_r),
    .req   (in_req_r),
    .ctl   (ctl)
  );

  plt_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .ctl      (ctl),
    .vblank   (in_req_r.vblank),
    .sums_nxt (sums_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_user_r <= ctl.ok;
      out_data_r <= sums_nxt;
    end
  end

endmodule
